/* hdl/ile_pkg.sv */
// Shared constants, codes and types for the indexed list engine.
package ile_pkg;

    localparam int LIST_CAPACITY = 64;
    localparam int ENTRY_WIDTH   = 32;

    localparam int IDX_W = $clog2(LIST_CAPACITY);
    localparam int CNT_W = $clog2(LIST_CAPACITY + 1);

    // Field widths fixed by the port definition
    localparam int ACT_W      = 3;
    localparam int POS_W      = 7;
    localparam int DATA_W     = 32;
    localparam int FIDX_W     = 6;
    localparam int CNT_OUT_W  = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_READ   = 3'd2,
        ACT_WRITE  = 3'd3,
        ACT_SEARCH = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_ISSUE,
        ST_RD_CAP,
        ST_SHIFT,
        ST_WR_VAL,
        ST_SEARCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0]    data;
        logic [FIDX_W-1:0]    fidx;
        logic                 found;
        logic                 err;
        logic [CNT_OUT_W-1:0] count;
        logic                 empty;
        logic                 full;
    } res_t;

    typedef struct packed {
        logic                   we;
        logic [IDX_W-1:0]       waddr;
        logic [ENTRY_WIDTH-1:0] wdata;
        logic [IDX_W-1:0]       raddr;
    } ram_req_t;

endpackage

/* hdl/ile_if.sv */
// Valid/ready channel interfaces for requests and results.
interface ile_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [ile_pkg::ACT_W-1:0]             action;
    logic [ile_pkg::POS_W-1:0]             position;
    logic signed [ile_pkg::DATA_W-1:0]     value;

    modport source (output valid, output action, output position, output value,
                    input ready);
    modport sink   (input valid, input action, input position, input value,
                    output ready);
endinterface

interface ile_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ile_pkg::DATA_W-1:0]     data_out;
    logic [ile_pkg::FIDX_W-1:0]            found_index;
    logic                                  found;
    logic                                  error;
    logic [ile_pkg::CNT_OUT_W-1:0]         count;
    logic                                  empty_res;
    logic                                  full_res;

    modport source (output valid, output data_out, output found_index, output found,
                    output error, output count, output empty_res, output full_res,
                    input ready);
    modport sink   (input valid, input data_out, input found_index, input found,
                    input error, input count, input empty_res, input full_res,
                    output ready);
endinterface

/* hdl/ile_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/ile_ctrl.sv */
// Sequencer and shared pointer/compare datapath for list requests.
module ile_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  ile_pkg::req_t                       req,
    input  logic                                res_free,
    output logic                                done,
    output ile_pkg::res_t                       res,
    output ile_pkg::ram_req_t                   ram_req,
    input  logic [ile_pkg::ENTRY_WIDTH-1:0]     ram_rdata
);

    ile_pkg::state_t state_reg, state_next;

    logic [ile_pkg::ACT_W-1:0]       act_reg,   act_next;
    logic [ile_pkg::POS_W-1:0]       pos_reg,   pos_next;
    logic [ile_pkg::ENTRY_WIDTH-1:0] val_reg,   val_next;
    logic [ile_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [ile_pkg::CNT_W-1:0]       rem_reg,   rem_next;
    logic [ile_pkg::IDX_W-1:0]       ptr_reg,   ptr_next;
    logic [ile_pkg::IDX_W-1:0]       wa_reg,    wa_next;
    logic                            pend_reg,  pend_next;
    logic                            dir_up_reg, dir_up_next;
    logic [ile_pkg::DATA_W-1:0]      data_reg,  data_next;
    logic [ile_pkg::IDX_W-1:0]       fidx_reg,  fidx_next;
    logic                            found_reg, found_next;
    logic                            err_reg,   err_next;

    logic                            fire;
    logic                            bad_pos;
    logic                            bad_ins;
    logic [ile_pkg::CNT_W-1:0]       count_new;
    logic                            match;
    logic [ile_pkg::CNT_W-1:0]       del_moves;

    assign req_ready = (state_reg == ile_pkg::ST_IDLE);
    assign fire      = req_valid && req_ready;

    assign bad_pos = (32'(req.position) >= 32'(count_reg));
    assign bad_ins = (32'(count_reg) >= ile_pkg::LIST_CAPACITY) ||
                     (32'(req.position) > 32'(count_reg));
    assign match     = pend_reg && (ram_rdata == val_reg);
    assign del_moves = count_reg - ile_pkg::CNT_W'(pos_reg) - 1'b1;

    // Count after the request, applied on leaving the done state
    always_comb
    begin
        count_new = count_reg;
        if (!err_reg)
        begin
            case (ile_pkg::action_t'(act_reg))
                ile_pkg::ACT_INSERT: count_new = count_reg + 1'b1;
                ile_pkg::ACT_DELETE: count_new = count_reg - 1'b1;
                default:             count_new = count_reg;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ile_pkg::ST_IDLE:
            begin
                if (fire)
                begin
                    case (ile_pkg::action_t'(req.action))
                        ile_pkg::ACT_INSERT:
                            state_next = bad_ins ? ile_pkg::ST_DONE :
                                         ((32'(req.position) == 32'(count_reg)) ?
                                          ile_pkg::ST_WR_VAL : ile_pkg::ST_SHIFT);
                        ile_pkg::ACT_DELETE,
                        ile_pkg::ACT_READ:
                            state_next = bad_pos ? ile_pkg::ST_DONE : ile_pkg::ST_RD_ISSUE;
                        ile_pkg::ACT_WRITE:
                            state_next = bad_pos ? ile_pkg::ST_DONE : ile_pkg::ST_WR_VAL;
                        ile_pkg::ACT_SEARCH:
                            state_next = ile_pkg::ST_SEARCH;
                        default:
                            state_next = ile_pkg::ST_DONE;
                    endcase
                end
            end
            ile_pkg::ST_RD_ISSUE:
                state_next = ile_pkg::ST_RD_CAP;
            ile_pkg::ST_RD_CAP:
                state_next = ((ile_pkg::action_t'(act_reg) == ile_pkg::ACT_DELETE) &&
                              (del_moves != '0)) ? ile_pkg::ST_SHIFT : ile_pkg::ST_DONE;
            ile_pkg::ST_SHIFT:
            begin
                if (rem_reg == '0)
                begin
                    state_next = dir_up_reg ? ile_pkg::ST_WR_VAL : ile_pkg::ST_DONE;
                end
            end
            ile_pkg::ST_WR_VAL:
                state_next = ile_pkg::ST_DONE;
            ile_pkg::ST_SEARCH:
            begin
                if (match || rem_reg == '0)
                begin
                    state_next = ile_pkg::ST_DONE;
                end
            end
            ile_pkg::ST_DONE:
            begin
                if (res_free)
                begin
                    state_next = ile_pkg::ST_IDLE;
                end
            end
            default:
                state_next = ile_pkg::ST_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        act_next    = act_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        ptr_next    = ptr_reg;
        wa_next     = wa_reg;
        pend_next   = pend_reg;
        dir_up_next = dir_up_reg;
        data_next   = data_reg;
        fidx_next   = fidx_reg;
        found_next  = found_reg;
        err_next    = err_reg;
        done        = 1'b0;

        ram_req.we    = 1'b0;
        ram_req.waddr = wa_reg;
        ram_req.wdata = ram_rdata;
        ram_req.raddr = ptr_reg;

        case (state_reg)
            ile_pkg::ST_IDLE:
            begin
                if (fire)
                begin
                    act_next    = req.action;
                    pos_next    = req.position;
                    val_next    = ile_pkg::ENTRY_WIDTH'($unsigned(req.value));
                    data_next   = '0;
                    fidx_next   = '0;
                    found_next  = 1'b0;
                    pend_next   = 1'b0;
                    dir_up_next = 1'b1;
                    case (ile_pkg::action_t'(req.action))
                        ile_pkg::ACT_INSERT:
                        begin
                            err_next = bad_ins;
                            rem_next = count_reg - ile_pkg::CNT_W'(req.position);
                            ptr_next = ile_pkg::IDX_W'(count_reg - 1'b1);
                        end
                        ile_pkg::ACT_DELETE,
                        ile_pkg::ACT_READ,
                        ile_pkg::ACT_WRITE:
                        begin
                            err_next = bad_pos;
                        end
                        ile_pkg::ACT_SEARCH:
                        begin
                            err_next = 1'b0;
                            rem_next = count_reg;
                            ptr_next = '0;
                        end
                        default:
                        begin
                            err_next = 1'b1;
                        end
                    endcase
                end
            end
            ile_pkg::ST_RD_ISSUE:
            begin
                ram_req.raddr = ile_pkg::IDX_W'(pos_reg);
            end
            ile_pkg::ST_RD_CAP:
            begin
                data_next   = ile_pkg::DATA_W'(ram_rdata);
                rem_next    = del_moves;
                ptr_next    = ile_pkg::IDX_W'(pos_reg) + 1'b1;
                pend_next   = 1'b0;
                dir_up_next = 1'b0;
            end
            ile_pkg::ST_SHIFT:
            begin
                // Write back the word read last cycle, issue the next read
                ram_req.we = pend_reg;
                if (rem_reg != '0)
                begin
                    pend_next = 1'b1;
                    wa_next   = dir_up_reg ? ptr_reg + 1'b1 : ptr_reg - 1'b1;
                    ptr_next  = dir_up_reg ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
                    rem_next  = rem_reg - 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ile_pkg::ST_WR_VAL:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ile_pkg::IDX_W'(pos_reg);
                ram_req.wdata = val_reg;
            end
            ile_pkg::ST_SEARCH:
            begin
                if (match)
                begin
                    found_next = 1'b1;
                    fidx_next  = wa_reg;
                end
                else if (rem_reg != '0)
                begin
                    pend_next = 1'b1;
                    wa_next   = ptr_reg;
                    ptr_next  = ptr_reg + 1'b1;
                    rem_next  = rem_reg - 1'b1;
                end
            end
            ile_pkg::ST_DONE:
            begin
                if (res_free)
                begin
                    done       = 1'b1;
                    count_next = count_new;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    assign res.data  = data_reg;
    assign res.fidx  = ile_pkg::FIDX_W'(fidx_reg);
    assign res.found = found_reg;
    assign res.err   = err_reg;
    assign res.count = ile_pkg::CNT_OUT_W'(count_new);
    assign res.empty = (count_new == '0);
    assign res.full  = (32'(count_new) >= ile_pkg::LIST_CAPACITY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ile_pkg::ST_IDLE;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            rem_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            rem_reg    <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        ptr_reg    <= ptr_next;
        wa_reg     <= wa_next;
        dir_up_reg <= dir_up_next;
        data_reg   <= data_next;
        fidx_reg   <= fidx_next;
        found_reg  <= found_next;
        err_reg    <= err_next;
    end

endmodule

/* hdl/indexed_list_engine.sv */
// Top level of the indexed list engine: request sequencer, entry RAM, result register.
// Insert and delete shift the entries behind the position; search walks the list until a
// match or its end; read and write touch one slot; a bad request goes straight to done.
// One request at a time, walking the entry RAM a word per cycle. Worst case is a delete
// at slot 0 of a full list; the next request is taken once the result is registered.
// Reset clears count, state and result valid; RAM contents stay undefined until written.
module indexed_list_engine (
    input  logic       clk,
    input  logic       rst_n,
    ile_req_if.sink    req,
    ile_rsp_if.source  rsp
);

    ile_pkg::req_t     req_bus;
    ile_pkg::res_t     res;
    ile_pkg::ram_req_t ram_req;
    logic [ile_pkg::ENTRY_WIDTH-1:0] ram_rdata;
    logic              done;
    logic              res_free;
    logic              rsp_valid_reg, rsp_valid_next;
    ile_pkg::res_t     rsp_data_reg,  rsp_data_next;

    assign req_bus.action   = req.action;
    assign req_bus.position = req.position;
    assign req_bus.value    = req.value;

    // Result register frees up in the same cycle its transfer completes
    assign res_free = !rsp_valid_reg || rsp.ready;

    ile_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req       (req_bus),
        .res_free  (res_free),
        .done      (done),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // Entry storage: list kept contiguous from slot 0
    ile_ram #(
        .WIDTH (ile_pkg::ENTRY_WIDTH),
        .DEPTH (ile_pkg::LIST_CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Output register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (done)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.data_out    = $signed(rsp_data_reg.data);
    assign rsp.found_index = rsp_data_reg.fidx;
    assign rsp.found       = rsp_data_reg.found;
    assign rsp.error       = rsp_data_reg.err;
    assign rsp.count       = rsp_data_reg.count;
    assign rsp.empty_res   = rsp_data_reg.empty;
    assign rsp.full_res    = rsp_data_reg.full;

endmodule
